[rtl/core/wst_pkg.sv]
// ----------------------------------------------------------------------------
// wst_pkg: shared types and constants for the water session timer
// Request and result layouts, configuration record, register indexes,
// event codes and register reset values.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TIMER_ENABLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALERT_ENABLE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_TIME       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_TIME       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_LIMIT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TRIM_TIME      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COLD_SHOT_TIME = 3'd6;

  // Event codes reported with each result.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_STARTED  = 2'd1;
  localparam logic [1:0] EV_FINISHED = 2'd2;

  // Register values after reset.
  localparam logic [StampW-1:0] MIN_TIME_RST       = 32'd120000;
  localparam logic [StampW-1:0] MAX_TIME_RST       = 32'd420000;
  localparam logic [StampW-1:0] PAUSE_LIMIT_RST    = 32'd15000;
  localparam logic [StampW-1:0] TRIM_TIME_RST      = 32'd5000;
  localparam logic [StampW-1:0] COLD_SHOT_TIME_RST = 32'd10000;

  typedef struct packed {
    logic [StampW-1:0] now_ms;
    logic              water_active;
  } wst_in_t;

  typedef struct packed {
    logic              session_active;
    logic              cold_shot_on;
    logic [1:0]        event_code;
    logic [StampW-1:0] duration_ms;
  } wst_out_t;

  typedef struct packed {
    logic              timer_enable;
    logic              alert_enable;
    logic [StampW-1:0] min_time;
    logic [StampW-1:0] max_time;
    logic [StampW-1:0] pause_limit;
    logic [StampW-1:0] trim_time;
    logic [StampW-1:0] cold_shot_time;
  } wst_cfg_t;

endpackage

[rtl/core/wst_cfg.sv]
// ----------------------------------------------------------------------------
// wst_cfg: configuration registers
// Holds the seven timing and enable registers written through the plain
// write port. Writes to an index beyond the list are dropped.
// ----------------------------------------------------------------------------
module wst_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [wst_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [wst_pkg::StampW-1:0]  cfg_data,
  output wst_pkg::wst_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_enable   <= 1'b0;
      cfg.alert_enable   <= 1'b0;
      cfg.min_time       <= wst_pkg::MIN_TIME_RST;
      cfg.max_time       <= wst_pkg::MAX_TIME_RST;
      cfg.pause_limit    <= wst_pkg::PAUSE_LIMIT_RST;
      cfg.trim_time      <= wst_pkg::TRIM_TIME_RST;
      cfg.cold_shot_time <= wst_pkg::COLD_SHOT_TIME_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wst_pkg::REG_TIMER_ENABLE:   cfg.timer_enable   <= cfg_data[0];
        wst_pkg::REG_ALERT_ENABLE:   cfg.alert_enable   <= cfg_data[0];
        wst_pkg::REG_MIN_TIME:       cfg.min_time       <= cfg_data;
        wst_pkg::REG_MAX_TIME:       cfg.max_time       <= cfg_data;
        wst_pkg::REG_PAUSE_LIMIT:    cfg.pause_limit    <= cfg_data;
        wst_pkg::REG_TRIM_TIME:      cfg.trim_time      <= cfg_data;
        wst_pkg::REG_COLD_SHOT_TIME: cfg.cold_shot_time <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/wst_core.sv]
// ----------------------------------------------------------------------------
// wst_core: session state and per-tick update
// Keeps the session stamps and flags and computes, in one pass of short
// logic, the next state and the result for the tick held in the input stage.
// ----------------------------------------------------------------------------
module wst_core (
  input  logic              clk,
  input  logic              rst,
  input  wst_pkg::wst_cfg_t cfg,
  input  logic              step,
  input  wst_pkg::wst_in_t  tick,
  output wst_pkg::wst_out_t res
);

  logic [wst_pkg::StampW-1:0] start_stamp, start_stamp_next;
  logic [wst_pkg::StampW-1:0] pause_stamp, pause_stamp_next;
  logic [wst_pkg::StampW-1:0] cold_start_stamp, cold_start_stamp_next;
  logic                       session_flag, session_flag_next;
  logic                       cold_flag, cold_flag_next;

  logic [wst_pkg::StampW-1:0] cold_age;
  logic [wst_pkg::StampW-1:0] elapsed;
  logic [wst_pkg::StampW-1:0] pause_base;
  logic [wst_pkg::StampW-1:0] pause_age;
  logic [wst_pkg::StampW-1:0] run_len;
  logic [wst_pkg::StampW-1:0] trimmed;
  logic                       cold_live;

  assign cold_age = tick.now_ms - cold_start_stamp;
  assign elapsed  = tick.now_ms - start_stamp;
  // The pause stamp as it stands after this tick may latch it.
  assign pause_base = (start_stamp != '0 && pause_stamp == '0) ? tick.now_ms : pause_stamp;
  assign pause_age  = tick.now_ms - pause_base;
  assign run_len    = pause_base - start_stamp;
  assign trimmed    = run_len - cfg.trim_time;
  assign cold_live  = cold_flag && !(cold_age > cfg.cold_shot_time);

  always_comb begin
    start_stamp_next      = start_stamp;
    pause_stamp_next      = pause_stamp;
    cold_start_stamp_next = cold_start_stamp;
    session_flag_next     = session_flag;
    cold_flag_next        = cold_flag;
    res.event_code        = wst_pkg::EV_NONE;
    res.duration_ms       = '0;

    if (cfg.timer_enable) begin
      cold_flag_next = cold_live;
      if (!cold_live) begin
        if (tick.water_active) begin
          if (start_stamp == '0) begin
            start_stamp_next  = tick.now_ms;
            pause_stamp_next  = '0;
            session_flag_next = 1'b0;
          end else if (!session_flag && elapsed > cfg.min_time) begin
            session_flag_next = 1'b1;
            res.event_code    = wst_pkg::EV_STARTED;
          end else if (elapsed > cfg.max_time && cfg.alert_enable) begin
            cold_flag_next        = 1'b1;
            cold_start_stamp_next = tick.now_ms;
          end
        end else begin
          pause_stamp_next = pause_base;
          if (pause_base != '0 && pause_age > cfg.pause_limit) begin
            if (run_len > cfg.trim_time && trimmed > cfg.min_time) begin
              res.event_code  = wst_pkg::EV_FINISHED;
              res.duration_ms = trimmed;
            end
            start_stamp_next  = '0;
            pause_stamp_next  = '0;
            session_flag_next = 1'b0;
            cold_flag_next    = 1'b0;
          end
        end
      end
    end

    res.session_active = session_flag_next;
    res.cold_shot_on   = cold_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_stamp      <= '0;
      pause_stamp      <= '0;
      cold_start_stamp <= '0;
      session_flag     <= 1'b0;
      cold_flag        <= 1'b0;
    end else if (step) begin
      start_stamp      <= start_stamp_next;
      pause_stamp      <= pause_stamp_next;
      cold_start_stamp <= cold_start_stamp_next;
      session_flag     <= session_flag_next;
      cold_flag        <= cold_flag_next;
    end
  end

  // A finished session always reports a length above the minimum.
  a_finish_len: assert property (@(posedge clk) disable iff (rst)
    (step && res.event_code == wst_pkg::EV_FINISHED) |-> res.duration_ms > cfg.min_time)
    else $error("finished session reported with a short duration");

  // A start event leaves the session marked active.
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    (step && res.event_code == wst_pkg::EV_STARTED) |=> session_flag)
    else $error("session start event without active session");

  // With tracking off, a tick leaves the session state untouched.
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.timer_enable) |=>
      ($stable(start_stamp) && $stable(pause_stamp) && $stable(cold_flag)))
    else $error("session state changed while tracking disabled");

  // A closed session leaves no pause pending.
  a_idle_no_pause: assert property (@(posedge clk) disable iff (rst)
    (start_stamp == '0 && $past(start_stamp) != '0) |-> pause_stamp == '0)
    else $error("pause stamp left behind after session closed");

endmodule

[rtl/core/water_session_timer.sv]
// ----------------------------------------------------------------------------
// water_session_timer: hot-water session tracker
// Follows a stream of millisecond ticks with a flow flag, recognizes
// sessions, raises and clears the cold shot alert and reports finished
// sessions with their trimmed length.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload     Per request
//  --------  ---------------------  ----------  -----------------------------
//  in        in_valid / in_ready    in_data     one tick: timestamp and flow
//  out       out_valid / out_ready  out_data    one result for every tick
//  cfg       cfg_write              cfg_index,  one register write, no wait
//                                   cfg_data
//
// Each request is held in the input stage and then moves to the result
// register; one request can be taken every cycle while the output is not
// stalled. The only cost per request is a few 32-bit subtractions and
// compares against the session stamps between those two registers.
// Reset clears the session state, the stage valid flags and the registers to
// their documented values. A stalled output holds its result; the input stage
// still takes one more request, and further requests wait on in_ready.
//
module water_session_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wst_pkg::wst_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wst_pkg::wst_out_t           out_data,
  input  logic                        cfg_write,
  input  logic [wst_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [wst_pkg::StampW-1:0]  cfg_data
);

  wst_pkg::wst_cfg_t cfg;
  wst_pkg::wst_in_t  tick;
  wst_pkg::wst_out_t res;
  logic              tick_valid;
  logic              advance;

  // The held request moves on whenever the result register is empty or is
  // being emptied in this cycle. The session state updates at that same edge,
  // so requests are processed strictly in arrival order.
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  wst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wst_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .tick (tick),
    .res  (res)
  );

  // Input stage: the valid flag is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the water session timer
// Drives tick requests through the valid/ready input, predicts every result
// with an independent session tracker, and compares the results field by
// field. Directed sequences cover the special cases; random sessions follow
// under several register settings, with random idling and back pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The port has room for one index beyond the register list; writes there
  // must leave every register untouched.
  localparam logic [wst_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int unsigned StallLimit = 3000;
  // Tick requests per random phase, and how many random phases there are.
  localparam int unsigned PhaseTicks = 260;
  localparam int unsigned PhaseCount = 7;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  wst_pkg::wst_in_t            in_data;
  logic                        out_valid;
  logic                        out_ready;
  wst_pkg::wst_out_t           out_data;
  logic                        cfg_write;
  logic [wst_pkg::CfgIdxW-1:0] cfg_index;
  logic [wst_pkg::StampW-1:0]  cfg_data;

  water_session_timer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the register file and of the session state. The copy is
  // advanced once for every tick request that the block accepts.
  wst_pkg::wst_cfg_t          regs;
  logic [wst_pkg::StampW-1:0] flow_start;
  logic [wst_pkg::StampW-1:0] pause_start;
  logic [wst_pkg::StampW-1:0] cold_since;
  logic                       sess_on;
  logic                       cold_on;

  // Results that the block still owes us, oldest first.
  wst_pkg::wst_out_t tick_results[$];

  int unsigned                mismatch_count;
  int unsigned                results_seen;
  bit                         gaps_on;      // random idling on both channels
  int unsigned                hold_cycles;  // long receiver hold-off, counted down below
  logic [wst_pkg::StampW-1:0] wall_ms;      // running timestamp for the session stimulus

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_predictor();
    regs = '{timer_enable: 1'b0, alert_enable: 1'b0,
             min_time: wst_pkg::MIN_TIME_RST, max_time: wst_pkg::MAX_TIME_RST,
             pause_limit: wst_pkg::PAUSE_LIMIT_RST, trim_time: wst_pkg::TRIM_TIME_RST,
             cold_shot_time: wst_pkg::COLD_SHOT_TIME_RST};
    flow_start  = '0;
    pause_start = '0;
    cold_since  = '0;
    sess_on     = 1'b0;
    cold_on     = 1'b0;
  endfunction

  // Advances the session state by one tick and returns the result that the
  // block must produce for it. All differences wrap modulo 2^32 because every
  // operand is a 32-bit vector.
  function automatic wst_pkg::wst_out_t predict_tick(input wst_pkg::wst_in_t t);
    wst_pkg::wst_out_t          r;
    logic [wst_pkg::StampW-1:0] cold_ms;
    logic [wst_pkg::StampW-1:0] run_ms;
    logic [wst_pkg::StampW-1:0] idle_ms;
    logic [wst_pkg::StampW-1:0] span_ms;
    logic [wst_pkg::StampW-1:0] net_ms;
    r = '0;
    r.event_code = wst_pkg::EV_NONE;
    if (regs.timer_enable) begin
      // The cold shot expiry is looked at before anything else.
      cold_ms = t.now_ms - cold_since;
      if (cold_on && cold_ms > regs.cold_shot_time) begin
        cold_on = 1'b0;
      end
      if (!cold_on) begin
        if (t.water_active) begin
          if (flow_start == '0) begin
            // A start taken at stamp zero still reads as idle afterwards.
            flow_start  = t.now_ms;
            pause_start = '0;
            sess_on     = 1'b0;
          end else begin
            run_ms = t.now_ms - flow_start;
            if (!sess_on && run_ms > regs.min_time) begin
              sess_on      = 1'b1;
              r.event_code = wst_pkg::EV_STARTED;
            end else if (run_ms > regs.max_time && regs.alert_enable) begin
              cold_on    = 1'b1;
              cold_since = t.now_ms;
            end
          end
        end else begin
          if (flow_start != '0 && pause_start == '0) begin
            pause_start = t.now_ms;
          end
          idle_ms = t.now_ms - pause_start;
          if (pause_start != '0 && idle_ms > regs.pause_limit) begin
            span_ms = pause_start - flow_start;
            net_ms  = span_ms - regs.trim_time;
            if (span_ms > regs.trim_time && net_ms > regs.min_time) begin
              r.event_code  = wst_pkg::EV_FINISHED;
              r.duration_ms = net_ms;
            end
            flow_start  = '0;
            pause_start = '0;
            sess_on     = 1'b0;
            cold_on     = 1'b0;
          end
        end
      end
    end
    r.session_active = sess_on;
    r.cold_shot_on   = cold_on;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Offers one tick request and waits until the block takes it. The valid
  // line is only lowered when a random gap is inserted, so back-to-back
  // requests keep it high without a glitch.
  task automatic send_tick(input logic [wst_pkg::StampW-1:0] stamp, input logic flow);
    wst_pkg::wst_in_t t;
    t.now_ms       = stamp;
    t.water_active = flow;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    tick_results.push_back(predict_tick(t));
  endtask

  // Stops offering requests and waits until every result has come back, and
  // then lets the two-stage pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic put_reg(input logic [wst_pkg::CfgIdxW-1:0] idx,
                         input logic [wst_pkg::StampW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all seven registers while the block is idle. The one-bit
  // registers get random upper data bits, which the block must ignore, and a
  // write to the spare index follows, which must change nothing.
  task automatic load_registers(input wst_pkg::wst_cfg_t c);
    logic [wst_pkg::StampW-1:0] pad;
    settle();
    pad = $urandom();
    put_reg(wst_pkg::REG_TIMER_ENABLE, {pad[wst_pkg::StampW-1:1], c.timer_enable});
    pad = $urandom();
    put_reg(wst_pkg::REG_ALERT_ENABLE, {pad[wst_pkg::StampW-1:1], c.alert_enable});
    put_reg(wst_pkg::REG_MIN_TIME, c.min_time);
    put_reg(wst_pkg::REG_MAX_TIME, c.max_time);
    put_reg(wst_pkg::REG_PAUSE_LIMIT, c.pause_limit);
    put_reg(wst_pkg::REG_TRIM_TIME, c.trim_time);
    put_reg(wst_pkg::REG_COLD_SHOT_TIME, c.cold_shot_time);
    put_reg(REG_SPARE, $urandom());
    cfg_write <= 1'b0;
    regs = c;
  endtask

  // Short durations so that random sessions of a few dozen milliseconds
  // reach every decision in the tracker.
  function automatic wst_pkg::wst_cfg_t short_cfg();
    wst_pkg::wst_cfg_t c;
    c.timer_enable   = 1'b1;
    c.alert_enable   = ($urandom_range(0, 4) != 0);
    c.min_time       = $urandom_range(0, 200);
    c.max_time       = $urandom_range(0, 400);
    c.pause_limit    = $urandom_range(0, 60);
    c.trim_time      = $urandom_range(0, 100);
    c.cold_shot_time = $urandom_range(0, 80);
    return c;
  endfunction

  // Mostly well-formed sessions (a run of flow ticks, then a run of pause
  // ticks) with random spacing, mixed with stray ticks at arbitrary stamps
  // and short walks across the timestamp wrap that land a tick on zero.
  task automatic run_sessions(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned flows;
    int unsigned rests;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        flows = $urandom_range(1, 14);
        rests = $urandom_range(1, 6);
        repeat (flows) begin
          wall_ms += $urandom_range(0, 40);
          send_tick(wall_ms, 1'b1);
        end
        repeat (rests) begin
          wall_ms += $urandom_range(0, 30);
          send_tick(wall_ms, 1'b0);
        end
        sent += flows + rests;
      end else if (pick < 18) begin
        send_tick($urandom(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
        repeat (6) begin
          send_tick(wall_ms, 1'($urandom_range(0, 1)));
          wall_ms += 1;
        end
        sent += 6;
      end
    end
  endtask

  // After reset tracking is off: ticks at the stamp extremes change nothing.
  task automatic test_disabled_ticks();
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'd0, 1'b0);
  endtask

  // Only the enable is written, so this session runs on the reset values of
  // the other registers: it starts, runs past the maximum with alerts off,
  // and finishes with a reported length.
  task automatic test_reset_registers();
    settle();
    put_reg(wst_pkg::REG_TIMER_ENABLE, 32'd1);
    cfg_write <= 1'b0;
    regs.timer_enable = 1'b1;
    send_tick(32'd1000, 1'b1);
    send_tick(32'd121001, 1'b1);
    send_tick(32'd500000, 1'b1);
    send_tick(32'd600000, 1'b0);
    send_tick(32'd615001, 1'b0);
  endtask

  task automatic test_special_cases();
    load_registers('{timer_enable: 1'b1, alert_enable: 1'b1, min_time: 32'd100,
                     max_time: 32'd50, pause_limit: 32'd20, trim_time: 32'd10,
                     cold_shot_time: 32'd30});
    // A start at stamp zero is taken again on the next flow tick. With the
    // maximum below the minimum the alert fires before the session is
    // active; it expires, is checked first, and fires again on the same tick.
    send_tick(32'd0, 1'b1);
    send_tick(32'd5, 1'b1);
    send_tick(32'd60, 1'b1);
    send_tick(32'd80, 1'b1);
    send_tick(32'd95, 1'b1);
    send_tick(32'd130, 1'b1);
    send_tick(32'd140, 1'b0);
    send_tick(32'd161, 1'b0);
    // A session too short to survive the trim closes without a report.
    send_tick(32'd200, 1'b1);
    send_tick(32'd210, 1'b0);
    send_tick(32'd231, 1'b0);
    // Across the wrap: a pause taken at stamp zero does not count as one.
    send_tick(32'hFFFF_FFF0, 1'b1);
    send_tick(32'd0, 1'b0);
    send_tick(32'd1, 1'b0);
    send_tick(32'd22, 1'b0);
    // With tracking switched off mid-session, the state stays frozen.
    send_tick(32'd300, 1'b1);
    send_tick(32'd401, 1'b1);
    settle();
    put_reg(wst_pkg::REG_TIMER_ENABLE, 32'd0);
    cfg_write <= 1'b0;
    regs.timer_enable = 1'b0;
    send_tick(32'd1000, 1'b0);
    send_tick(32'd0, 1'b1);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the pipeline fills and the block has to drop in_ready.
  task automatic test_backpressure();
    load_registers(short_cfg());
    gaps_on     = 1'b0;
    hold_cycles = 80;
    run_sessions(30);
    gaps_on     = 1'b1;
  endtask

  // Random sessions under several settings: all durations zero, all at the
  // top of their range, then random short ones. The last phase runs without
  // idling on either side.
  task automatic test_random_sessions();
    wst_pkg::wst_cfg_t c;
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      if (p == 0) begin
        c = '{timer_enable: 1'b1, alert_enable: 1'b1, default: '0};
      end else if (p == 1) begin
        c = '{timer_enable: 1'b1, alert_enable: 1'b1, default: '1};
      end else begin
        c = short_cfg();
      end
      gaps_on = (p != PhaseCount - 1);
      load_registers(c);
      run_sessions(PhaseTicks);
    end
  endtask

  // Receiver: takes results, stalling in random bursts, and carries out the
  // long hold-off when a test asks for one.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result taken at a clock edge is matched with the oldest prediction.
  // Values are read right at the edge, before any update that the edge causes.
  always @(posedge clk) begin : result_check
    wst_pkg::wst_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (tick_results.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with no tick request pending",
                               results_seen));
      end else begin
        want = tick_results.pop_front();
        if (out_data.session_active !== want.session_active ||
            out_data.cold_shot_on !== want.cold_shot_on ||
            out_data.event_code !== want.event_code ||
            out_data.duration_ms !== want.duration_ms) begin
          log_mismatch($sformatf({"result %0d: expected active=%0b cold=%0b event=%0d",
                                  " duration=%0d, got active=%0b cold=%0b event=%0d",
                                  " duration=%0d"},
            results_seen, want.session_active, want.cold_shot_on, want.event_code,
            want.duration_ms, out_data.session_active, out_data.cold_shot_on,
            out_data.event_code, out_data.duration_ms));
        end
      end
    end
  end

  // Watchdog: a run where nothing moves on either channel for too long has
  // hung, and is ended as a failure.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_predictor();
    mismatch_count = 0;
    results_seen   = 0;
    gaps_on        = 1'b1;
    hold_cycles    = 0;
    wall_ms        = 32'd1000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_ticks();
    test_reset_registers();
    test_special_cases();
    test_backpressure();
    test_random_sessions();

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
